// ----- sv/apts_pkg.sv -----
// package for the aging priority task scheduler
// holds opcodes, sizes and the sequencer state type; no dependencies
`timescale 1ns / 1ps
package apts_pkg;
   localparam int TASKS = 16;
   localparam int IDW = $clog2(TASKS);
   localparam int CNTW = $clog2(TASKS + 1);

   typedef enum logic [1:0] {
      OP_ENABLE = 2'd0,
      OP_RUN    = 2'd1,
      OP_LOAD   = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_GUARD,
      ST_AGE_START,
      ST_AGE_WAIT,
      ST_AGE_DONE,
      ST_RUN_END,
      ST_LOAD_MUL,
      ST_LOAD_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage

// ----- sv/apts_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// shared by task aging and the load average; uses apts_pkg
`timescale 1ns / 1ps
module apts_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  apts_pkg::div_req_type req,
   output apts_pkg::div_rsp_type rsp
);
   import apts_pkg::*;

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in    = 32'(trial - {1'b0, dsr_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ----- sv/aging_priority_task_scheduler.sv -----
// aging priority task scheduler, top level
// depends on apts_pkg and apts_divider
//
// usage: drive req_* with start high while busy is low; the item is taken
// at that edge and busy rises. exactly one result per item appears on the
// rsp_* ports for one cycle with rsp_valid high, then busy falls.
// opcodes: enable/disable a task, run the scheduler at req_current_time,
// take a load sample, read a task's last delta.
// steps: enable walks the queue one entry a cycle, then shifts the queue in
// the SHIFT state. a run walks the queue for the realtime guard, then ages
// each queued task with one pass of the shared bit-serial divider, skipped
// when the elapsed time is negative. a load sample takes one 64-bit division,
// or none with no samples. a query is answered from the stored deltas.
// one item at a time: busy stays high until the result has been shown.
// the receiver cannot stall; results must be taken when rsp_valid is high.
// csr_we writes realtime_priority; the user must do so only while busy is low,
// which the block does not enforce. reset (synchronous, active high) empties
// the queue, clears the per task run times, dynamic priorities and deltas, the
// load accumulators, and sets realtime_priority to 6.
module aging_priority_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_task_id,
   input  logic        req_enable,
   input  logic [3:0]  req_static_priority,
   input  logic [31:0] req_period,
   input  logic [31:0] req_current_time,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic        rsp_selected_valid,
   output logic [3:0]  rsp_selected_task,
   output logic [4:0]  rsp_waiting_count,
   output logic [15:0] rsp_load_percent,
   output logic [31:0] rsp_delta_time
);
   import apts_pkg::*;

   state_type state_ff, state_in;

   logic [3:0]      rtp_ff;
   logic [IDW-1:0]  order_ff [TASKS];
   logic [CNTW-1:0] qlen_ff;
   logic [3:0]      prio_ff [TASKS];
   logic [31:0]     per_ff [TASKS];
   logic [31:0]     lrt_ff [TASKS];
   logic [15:0]     dyn_ff [TASKS];
   logic [31:0]     dlt_ff [TASKS];
   logic [31:0]     wtot_ff, scnt_ff;
   logic [15:0]     load_ff;

   // item latches
   logic [1:0]      op_ff;
   logic [3:0]      id_ff;
   logic            en_ff;
   logic [3:0]      sp_ff;
   logic [31:0]     rper_ff, now_ff;

   // sequencer registers
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [CNTW-1:0] pos_ff, pos_in;
   logic            found_ff, found_in;
   logic            ins_ff, ins_in;
   logic [31:0]     guard_ff, guard_in;
   logic            grd_on_ff, grd_on_in;
   logic [15:0]     best_ff;
   logic            sel_v_ff;
   logic [IDW-1:0]  sel_ff;
   logic [CNTW-1:0] wait_ff;
   logic [31:0]     age_ff;
   logic [63:0]     lmul_ff;
   logic            acc_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   apts_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic            in_range;
   logic [IDW-1:0]  cur_t;
   logic [31:0]     next_t, gdiff, elapsed, per_eff;
   logic [35:0]     dprod;
   logic [15:0]     dnew, dcur;
   logic            allowed;

   assign in_range = ({28'd0, req_task_id} < 32'(TASKS));
   assign cur_t    = order_ff[idx_ff[IDW-1:0]];
   assign next_t   = lrt_ff[cur_t] + per_ff[cur_t];
   assign gdiff    = now_ff - next_t;
   assign elapsed  = now_ff - lrt_ff[cur_t];
   assign per_eff  = (per_ff[cur_t] == 32'd0) ? 32'd1 : per_ff[cur_t];
   assign dprod    = 36'(prio_ff[cur_t]) * 36'(age_ff) + 36'd1;
   assign dnew     = (dprod > 36'd65535) ? 16'hffff : dprod[15:0];
   assign dcur     = (age_ff != 32'd0) ? dnew : dyn_ff[cur_t];
   assign allowed  = (guard_ff != 32'd0) || (age_ff > 32'd1) ||
                     (prio_ff[cur_t] == rtp_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (opcode_type'(req_opcode))
                  OP_ENABLE: state_in = in_range ? ST_FIND : ST_RESP;
                  OP_RUN:    state_in = ST_GUARD;
                  OP_LOAD:   state_in = ST_LOAD_MUL;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_FIND:      if (idx_ff >= qlen_ff) state_in = ST_SHIFT;
         ST_SHIFT:     state_in = ST_RESP;
         ST_GUARD: begin
            if (idx_ff >= qlen_ff || !grd_on_ff || prio_ff[cur_t] < rtp_ff)
               state_in = ST_AGE_START;
         end
         ST_AGE_START: begin
            // negative elapsed skips the divider: go straight on with age 0
            if (idx_ff >= qlen_ff) state_in = ST_RUN_END;
            else if (elapsed[31]) state_in = ST_AGE_DONE;
            else state_in = ST_AGE_WAIT;
         end
         ST_AGE_WAIT:  if (drsp.done) state_in = ST_AGE_DONE;
         ST_AGE_DONE:  state_in = ST_AGE_START;
         ST_RUN_END:   state_in = ST_IDLE;
         ST_LOAD_MUL:  state_in = (scnt_ff == 32'd0) ? ST_RESP : ST_LOAD_WAIT;
         ST_LOAD_WAIT: if (drsp.done) state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer datapath controls
   always_comb begin
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      ins_in    = ins_ff;
      guard_in  = guard_ff;
      grd_on_in = grd_on_ff;
      dreq.start    = 1'b0;
      dreq.dividend = {32'd0, elapsed};
      dreq.divisor  = per_eff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in    = '0;
            pos_in    = qlen_ff;
            found_in  = 1'b0;
            ins_in    = 1'b0;
            guard_in  = 32'hffffffff;
            grd_on_in = 1'b1;
         end
         ST_FIND: begin
            if (idx_ff < qlen_ff) begin
               if (cur_t == id_ff[IDW-1:0] && !found_in) begin
                  found_in = 1'b1;
                  if (!en_ff) pos_in = idx_ff;
               end
               if (en_ff && !ins_ff && prio_ff[cur_t] < sp_ff) begin
                  ins_in = 1'b1;
                  pos_in = idx_ff;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = qlen_ff;
            end
         end
         ST_GUARD: begin
            if (idx_ff < qlen_ff && grd_on_ff && prio_ff[cur_t] >= rtp_ff) begin
               if (!gdiff[31]) guard_in = 32'd0;
               else if (next_t - now_ff < guard_ff) guard_in = next_t - now_ff;
               idx_in = idx_ff + 1'b1;
            end else begin
               grd_on_in = 1'b0;
               idx_in    = '0;
            end
         end
         ST_AGE_START: begin
            if (idx_ff < qlen_ff && !elapsed[31]) dreq.start = 1'b1;
         end
         ST_AGE_DONE:  idx_in = idx_ff + 1'b1;
         ST_LOAD_MUL: begin
            dreq.dividend = 64'(wtot_ff) * 64'd100;
            dreq.divisor  = scnt_ff;
            dreq.start    = 1'b0;
         end
         default: ;
      endcase
      if (state_ff == ST_LOAD_WAIT && op_ff == OP_LOAD && lmul_ff[63] == 1'b0 &&
          idx_ff == '0) begin
         dreq.dividend = lmul_ff;
         dreq.divisor  = scnt_ff;
         dreq.start    = 1'b1;
         idx_in        = CNTW'(1);
      end
   end

   logic shift_do;
   logic [CNTW-1:0] ins_pos;
   assign ins_pos  = ins_ff ? pos_ff : qlen_ff;
   assign shift_do = (state_ff == ST_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rtp_ff   <= 4'd6;
         qlen_ff  <= '0;
         wtot_ff  <= '0;
         scnt_ff  <= '0;
         load_ff  <= '0;
         for (int i = 0; i < TASKS; i++) begin
            lrt_ff[i] <= '0;
            dyn_ff[i] <= '0;
            dlt_ff[i] <= '0;
         end
         acc_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) rtp_ff <= csr_wdata;
         if (shift_do) begin
            if (en_ff) begin
               if (!found_ff && qlen_ff < CNTW'(TASKS)) begin
                  for (int i = 1; i < TASKS; i++)
                     if (CNTW'(i) > ins_pos && CNTW'(i) <= qlen_ff)
                        order_ff[i] <= order_ff[i-1];
                  order_ff[ins_pos[IDW-1:0]] <= id_ff[IDW-1:0];
                  prio_ff[id_ff[IDW-1:0]] <= sp_ff;
                  per_ff[id_ff[IDW-1:0]]  <= rper_ff;
                  qlen_ff <= qlen_ff + 1'b1;
                  acc_ff  <= 1'b1;
               end else acc_ff <= 1'b0;
            end else begin
               if (found_ff) begin
                  for (int i = 0; i < TASKS - 1; i++)
                     if (CNTW'(i) >= pos_ff && CNTW'(i + 1) < qlen_ff)
                        order_ff[i] <= order_ff[i+1];
                  qlen_ff <= qlen_ff - 1'b1;
                  acc_ff  <= 1'b1;
               end else acc_ff <= 1'b0;
            end
         end else if (state_ff == ST_IDLE) begin
            acc_ff <= 1'b0;
         end
         if (state_ff == ST_AGE_DONE) begin
            if (age_ff != 32'd0) dyn_ff[cur_t] <= dnew;
         end
         if (state_ff == ST_RUN_END) begin
            scnt_ff <= scnt_ff + 32'd1;
            wtot_ff <= wtot_ff + 32'(wait_ff);
            if (sel_v_ff) begin
               dlt_ff[sel_ff] <= now_ff - lrt_ff[sel_ff];
               lrt_ff[sel_ff] <= now_ff;
               dyn_ff[sel_ff] <= '0;
            end
         end
         if (state_ff == ST_LOAD_WAIT && drsp.done) begin
            load_ff <= (drsp.quotient > 64'd65535) ? 16'hffff : drsp.quotient[15:0];
            scnt_ff <= '0;
            wtot_ff <= '0;
         end
      end
      if (state_ff == ST_IDLE && start) begin
         op_ff   <= req_opcode;
         id_ff   <= req_task_id;
         en_ff   <= req_enable;
         sp_ff   <= req_static_priority;
         rper_ff <= req_period;
         now_ff  <= req_current_time;
         best_ff  <= '0;
         sel_v_ff <= 1'b0;
         sel_ff   <= '0;
         wait_ff  <= '0;
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      ins_ff    <= ins_in;
      guard_ff  <= guard_in;
      grd_on_ff <= grd_on_in;
      if (state_ff == ST_AGE_START) age_ff <= '0;
      if (state_ff == ST_AGE_WAIT && drsp.done) age_ff <= drsp.quotient[31:0];
      if (state_ff == ST_AGE_DONE) begin
         if (age_ff != 32'd0) wait_ff <= wait_ff + 1'b1;
         if (dcur > best_ff && allowed) begin
            best_ff  <= dcur;
            sel_ff   <= cur_t;
            sel_v_ff <= 1'b1;
         end
      end
      if (state_ff == ST_LOAD_MUL) lmul_ff <= 64'(wtot_ff) * 64'd100;
   end

   // outputs
   always_comb begin
      busy               = (state_ff != ST_IDLE);
      rsp_valid          = 1'b0;
      rsp_accepted       = 1'b0;
      rsp_selected_valid = 1'b0;
      rsp_selected_task  = '0;
      rsp_waiting_count  = '0;
      rsp_load_percent   = '0;
      rsp_delta_time     = '0;
      if (state_ff == ST_RUN_END) begin
         rsp_valid          = 1'b1;
         rsp_selected_valid = sel_v_ff;
         rsp_selected_task  = sel_v_ff ? 4'(sel_ff) : 4'd0;
         rsp_waiting_count  = 5'(wait_ff);
      end else if (state_ff == ST_RESP) begin
         rsp_valid = 1'b1;
         unique case (opcode_type'(op_ff))
            OP_ENABLE: rsp_accepted = acc_ff;
            OP_LOAD:   rsp_load_percent = load_ff;
            OP_QUERY:  rsp_delta_time = dlt_ff[id_ff[IDW-1:0]];
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_len: assert property (@(posedge clock) disable iff (reset)
      qlen_ff <= CNTW'(TASKS)) else $error("queue length over capacity");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results for one item");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
`endif
endmodule
